>>> rtl/core/vram_update_list_writer_defines.svh
// -----------------------------------------------------------------------------
// vram update list writer assertion macros
// concurrent assertion wrappers clocked on clk_i, disabled during reset
// -----------------------------------------------------------------------------
`ifndef VRAM_UPDATE_LIST_WRITER_DEFINES_SVH
`define VRAM_UPDATE_LIST_WRITER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property checked on every clock edge outside reset
`define VULW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vram update list writer assertion failed");

// implication checked on every clock edge outside reset
`define VULW_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vram update list writer implication failed");

`else

`define VULW_ASSERT(lbl, prop)
`define VULW_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

>>> rtl/core/vulw_pkg.sv
// -----------------------------------------------------------------------------
// vulw_pkg
// shared types and constants of the vram update list writer
// -----------------------------------------------------------------------------
package vulw_pkg;

  localparam int unsigned OUT_ADDR_BITS = 14;
  localparam int unsigned COUNT_BITS    = 9;

  // list byte codes
  localparam logic [7:0] TYPE_END     = 8'h00;
  localparam logic [7:0] TYPE_ROW     = 8'h02;
  localparam logic [7:0] TYPE_COUNTED = 8'h03;
  localparam logic [7:0] END_MARK     = 8'hFF;

  // one result transaction
  typedef struct packed {
    logic                     we;
    logic [OUT_ADDR_BITS-1:0] addr;
    logic [7:0]               data;
    logic                     last;
  } res_t;

endpackage

>>> rtl/core/vram_update_list_writer.sv
// -----------------------------------------------------------------------------
// vram_update_list_writer
// decodes a video memory update list, one byte in, one write result out
// -----------------------------------------------------------------------------
// usage:
//   the slave stream s_axis carries the update list one byte per transaction.
//   the master stream m_axis gives exactly one result per input byte: tuser
//   says whether the byte is written to video memory, tdata holds address and
//   data of that write (both zero when no write), tlast flags a zero type byte
//   that ended the list.
// throughput:
//   one byte per cycle sustained while m_axis_tready holds; a result is registered in
//   the output register, or in the skid register while that is full. the decode is a
//   single pass of small logic between the command state registers and the output register.
// stalls:
//   an output register plus a one-entry skid register part the two sides, so
//   one more byte is taken while a result waits; s_axis_tready drops only when
//   both are full, and nothing is lost or repeated.
// reset:
//   rst_ni clears the stream registers and returns the decoder to waiting for
//   a type byte with cursor address zero.
`include "vram_update_list_writer_defines.svh"

module vram_update_list_writer
  import vulw_pkg::*;
#(
  parameter int unsigned ADDR_BITS  = 14,
  parameter int unsigned ROW_STRIDE = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // list byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] list_byte
  // write result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [13:0] write_address, [21:14] write_data, zero pad
  output logic        m_axis_tuser,   // [0] write_enable
  output logic        m_axis_tlast    // list_end
);

  // decoder phases
  localparam logic [2:0] PH_TYPE    = 3'd0;
  localparam logic [2:0] PH_HI      = 3'd1;
  localparam logic [2:0] PH_LO      = 3'd2;
  localparam logic [2:0] PH_COUNT   = 3'd3;
  localparam logic [2:0] PH_COUNTED = 3'd4;
  localparam logic [2:0] PH_DATA    = 3'd5;

  localparam int unsigned EXT_BITS = 16;

  logic [2:0]            phase_q, phase_d;
  logic [ADDR_BITS-1:0]  cursor_q, cursor_d;
  logic                  row_mode_q, row_mode_d;
  logic                  cnt_mode_q, cnt_mode_d;
  logic [COUNT_BITS-1:0] remain_q, remain_d;

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  res_t res;

  logic                 in_fire;
  logic [7:0]           lb;
  logic [EXT_BITS-1:0]  cursor_ext;
  logic [EXT_BITS-1:0]  hi_ext;
  logic [ADDR_BITS-1:0] step;

  assign s_axis_tready = !skid_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign lb            = s_axis_tdata;

  // cursor widened so the fixed output width can be cut from it
  assign cursor_ext = EXT_BITS'(cursor_q);
  assign hi_ext     = {lb, 8'h00};
  assign step       = row_mode_q ? ADDR_BITS'(ROW_STRIDE) : ADDR_BITS'(1);

  // single-pass decode of one list byte
  always_comb begin
    phase_d    = phase_q;
    cursor_d   = cursor_q;
    row_mode_d = row_mode_q;
    cnt_mode_d = cnt_mode_q;
    remain_d   = remain_q;
    res        = '0;
    case (phase_q)
      PH_HI: begin
        // bits above the address width are dropped
        cursor_d = hi_ext[ADDR_BITS-1:0];
        phase_d  = PH_LO;
      end
      PH_LO: begin
        cursor_d = cursor_q | ADDR_BITS'(lb);
        phase_d  = cnt_mode_q ? PH_COUNT : PH_DATA;
      end
      PH_COUNT: begin
        // a count of zero means a full run of 256
        remain_d = (lb == 8'h00) ? COUNT_BITS'(256) : COUNT_BITS'(lb);
        phase_d  = PH_COUNTED;
      end
      PH_COUNTED: begin
        // every counted byte is written, the end mark too
        res.we   = 1'b1;
        res.data = lb;
        res.addr = cursor_ext[OUT_ADDR_BITS-1:0];
        cursor_d = cursor_q + step;
        remain_d = remain_q - COUNT_BITS'(1);
        if (remain_q == COUNT_BITS'(1)) begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        if (lb == END_MARK) begin
          phase_d = PH_TYPE;
        end else begin
          res.we   = 1'b1;
          res.data = lb;
          res.addr = cursor_ext[OUT_ADDR_BITS-1:0];
          cursor_d = cursor_q + step;
        end
      end
      default: begin
        // type byte; unused phase codes land here as well
        if (lb == TYPE_END) begin
          res.last = 1'b1;
          phase_d  = PH_TYPE;
        end else begin
          // types above 3 act as type 1
          row_mode_d = (lb == TYPE_ROW);
          cnt_mode_d = (lb == TYPE_COUNTED);
          phase_d    = PH_HI;
        end
      end
    endcase
  end

  // command state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_TYPE;
      cursor_q   <= '0;
      row_mode_q <= 1'b0;
      cnt_mode_q <= 1'b0;
      remain_q   <= '0;
    end else if (in_fire) begin
      phase_q    <= phase_d;
      cursor_q   <= cursor_d;
      row_mode_q <= row_mode_d;
      cnt_mode_q <= cnt_mode_d;
      remain_q   <= remain_d;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= res;
      end
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.data, out_q.addr};
  assign m_axis_tuser  = out_q.we;
  assign m_axis_tlast  = out_q.last;

  // checks
  `VULW_ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q)
  `VULW_ASSERT_IMPL(a_end_no_write, out_valid_q && out_q.last, !out_q.we)
  `VULW_ASSERT_IMPL(a_idle_payload_zero, out_valid_q && !out_q.we,
                    out_q.addr == '0 && out_q.data == 8'h00)
  `VULW_ASSERT_IMPL(a_counted_nonzero, phase_q == PH_COUNTED, remain_q != '0)
  `VULW_ASSERT(a_phase_legal, phase_q <= PH_DATA)

endmodule

>>> test/tb_vram_update_list_writer.sv
// -----------------------------------------------------------------------------
// tb_vram_update_list_writer
// streams update lists into the writer and checks every write result against
// a local decoder model; a short directed table comes first, then random
// commands under four idle and stall patterns
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_vram_update_list_writer
  import vulw_pkg::*;
();

  localparam int unsigned ADDR_BITS  = 14;
  localparam int unsigned ROW_STRIDE = 32;
  localparam int unsigned ITEM_GOAL  = 650;

  // type codes the package leaves out
  localparam logic [7:0] TYPE_STEP         = 8'h01;
  localparam logic [7:0] TYPE_OUT_OF_RANGE = 8'h07;
  // a count byte of zero asks for a full run of 256 bytes
  localparam logic [7:0] COUNT_FULL_RUN    = 8'h00;

  typedef enum logic [2:0] {
    EXP_TYPE,
    EXP_ADDR_HI,
    EXP_ADDR_LO,
    EXP_COUNT,
    IN_COUNTED_RUN,
    IN_OPEN_RUN
  } list_phase_e;

  // one row of the directed table; want is only used when typed is set
  typedef struct packed {
    logic [7:0] list_byte;
    logic       typed;
    res_t       want;
  } directed_row_t;

  localparam int unsigned N_DIRECTED = 26;

  // result fields in order: we, addr, data, last
  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // list end straight after reset
    '{TYPE_END,          1'b1, '{1'b0, 14'h0000, 8'h00, 1'b1}},
    // step-by-one command at the top of the address space, wrapping to zero
    '{TYPE_STEP,         1'b1, '{1'b0, 14'h0000, 8'h00, 1'b0}},
    '{8'hFF,             1'b1, '{1'b0, 14'h0000, 8'h00, 1'b0}},
    '{8'hFF,             1'b1, '{1'b0, 14'h0000, 8'h00, 1'b0}},
    '{8'hAB,             1'b1, '{1'b1, 14'h3FFF, 8'hAB, 1'b0}},
    '{8'h00,             1'b1, '{1'b1, 14'h0000, 8'h00, 1'b0}},
    '{END_MARK,          1'b1, '{1'b0, 14'h0000, 8'h00, 1'b0}},
    // row command wrapping past the top
    '{TYPE_ROW,          1'b1, '{1'b0, 14'h0000, 8'h00, 1'b0}},
    '{8'h3F,             1'b0, '0},
    '{8'hF0,             1'b0, '0},
    '{8'h55,             1'b0, '0},
    '{8'h12,             1'b0, '0},
    '{END_MARK,          1'b0, '0},
    // counted run of two, the terminator value written inside the run
    '{TYPE_COUNTED,      1'b0, '0},
    '{8'h00,             1'b0, '0},
    '{8'h10,             1'b0, '0},
    '{8'h02,             1'b0, '0},
    '{8'hFF,             1'b0, '0},
    '{8'h80,             1'b0, '0},
    '{8'h01,             1'b0, '0},
    '{END_MARK,          1'b0, '0},
    // type code above three acts as step-by-one
    '{TYPE_OUT_OF_RANGE, 1'b0, '0},
    '{8'h20,             1'b0, '0},
    '{8'h00,             1'b0, '0},
    '{8'h7E,             1'b0, '0},
    '{END_MARK,          1'b0, '0}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] list_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;            // [13:0] write_address, [21:14] write_data, zero pad
  logic        m_axis_tuser;            // [0] write_enable
  logic        m_axis_tlast;            // list_end

  // decoder model state
  list_phase_e          list_phase  = EXP_TYPE;
  logic [ADDR_BITS-1:0] cursor      = '0;
  logic                 row_cmd     = 1'b0;
  logic                 counted_cmd = 1'b0;
  logic [8:0]           run_left    = '0;

  res_t pending_writes [$];
  int   errors     = 0;
  int   bytes_sent = 0;
  int   idle_pct   = 0;
  int   stall_pct  = 0;

  vram_update_list_writer #(
    .ADDR_BITS  (ADDR_BITS),
    .ROW_STRIDE (ROW_STRIDE)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // the write at the cursor, then the cursor steps by one or by a row
  function automatic res_t write_at_cursor(input logic [7:0] b);
    res_t r;
    r      = '0;
    r.we   = 1'b1;
    r.addr = cursor;
    r.data = b;
    cursor = cursor + (row_cmd ? ADDR_BITS'(ROW_STRIDE) : ADDR_BITS'(1));
    return r;
  endfunction

  // advances the decoder model by one list byte and gives its result
  function automatic res_t vram_write_for_byte(input logic [7:0] b);
    res_t r;
    r = '0;
    case (list_phase)
      EXP_ADDR_HI: begin
        // bits above the address width are dropped
        cursor     = ADDR_BITS'({b, 8'h00});
        list_phase = EXP_ADDR_LO;
      end
      EXP_ADDR_LO: begin
        cursor     = cursor | ADDR_BITS'(b);
        list_phase = counted_cmd ? EXP_COUNT : IN_OPEN_RUN;
      end
      EXP_COUNT: begin
        run_left   = (b == COUNT_FULL_RUN) ? 9'd256 : {1'b0, b};
        list_phase = IN_COUNTED_RUN;
      end
      IN_COUNTED_RUN: begin
        // every byte of a counted run is written, end marks included
        r        = write_at_cursor(b);
        run_left = run_left - 9'd1;
        if (run_left == 9'd0) begin
          list_phase = IN_OPEN_RUN;
        end
      end
      IN_OPEN_RUN: begin
        if (b == END_MARK) begin
          list_phase = EXP_TYPE;
        end else begin
          r = write_at_cursor(b);
        end
      end
      default: begin
        if (b == TYPE_END) begin
          r.last = 1'b1;
        end else begin
          row_cmd     = (b == TYPE_ROW);
          counted_cmd = (b == TYPE_COUNTED);
          list_phase  = EXP_ADDR_HI;
        end
      end
    endcase
    return r;
  endfunction

  // one list byte transaction, with random idle cycles ahead of it; the model
  // advances at acceptance and a typed row overrides the predicted result
  task automatic send_list_byte(input logic [7:0] b, input logic typed = 1'b0,
                                input res_t want = '0);
    res_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = vram_write_for_byte(b);
    pending_writes.push_back(typed ? want : predicted);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // one random command: mostly well formed, sometimes noise, a list end, or a
  // run left open without its end mark
  task automatic send_update_command(input bit full_run);
    int         kind;
    int         n;
    logic [7:0] cmd;
    kind = full_run ? 99 : $urandom_range(99);
    if (kind < 6) begin
      n = $urandom_range(6, 1);
      repeat (n) send_list_byte(8'($urandom_range(255)));
    end else if (kind < 10) begin
      send_list_byte(TYPE_END);
    end else begin
      case ($urandom_range(3))
        0:       cmd = TYPE_STEP;
        1:       cmd = TYPE_ROW;
        2:       cmd = TYPE_COUNTED;
        default: cmd = 8'($urandom_range(255, 4));
      endcase
      if (full_run) begin
        cmd = TYPE_COUNTED;
      end
      send_list_byte(cmd);
      send_list_byte(8'($urandom_range(255)));
      send_list_byte(8'($urandom_range(255)));
      if (cmd == TYPE_COUNTED) begin
        // full 256-byte runs are rare so the run stays short
        n = (full_run || $urandom_range(49) == 0) ? 0 : $urandom_range(8, 1);
        send_list_byte(8'(n));
        repeat ((n == 0) ? 256 : n) send_list_byte(8'($urandom_range(255)));
      end
      n = $urandom_range(8, 0);
      repeat (n) send_list_byte(8'($urandom_range(254)));
      if ($urandom_range(19) != 0) begin
        send_list_byte(END_MARK);
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // result checker: each accepted transaction against the oldest prediction
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_writes.size() == 0) begin
        $error("result transaction with no list byte waiting for it");
        errors++;
      end else begin
        want = pending_writes.pop_front();
        check_field("write_enable",  want.we,   m_axis_tuser);
        check_field("write_address", want.addr, m_axis_tdata[13:0]);
        check_field("write_data",    want.data, m_axis_tdata[21:14]);
        check_field("list_end",      want.last, m_axis_tlast);
      end
    end
  end

  // stimulus and end of run
  initial begin
    int idle_by_phase  [4];
    int stall_by_phase [4];
    int goal;
    idle_by_phase  = '{0, 79, 0, 8};
    stall_by_phase = '{0, 0, 79, 8};
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      send_list_byte(DIRECTED_ROWS[i].list_byte, DIRECTED_ROWS[i].typed,
                     DIRECTED_ROWS[i].want);
    end

    // four idle and stall patterns; the first random command is a full 256-byte run
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      goal = N_DIRECTED + (p + 1) * (ITEM_GOAL - N_DIRECTED) / 4;
      if (p == 0) begin
        send_update_command(1'b1);
      end
      while (bytes_sent < goal) begin
        send_update_command(1'b0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_writes.size() != 0) @(posedge clk_i);
    // wait on so that any extra result is still caught
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("[vram_update_list_writer] OK");
    end else begin
      $display("[vram_update_list_writer] ERROR");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #2_000_000;
    $display("[vram_update_list_writer] ERROR");
    $finish;
  end

endmodule
